[hdl/noc_vca_pkg.sv]
// Shared types and constants for the first-free virtual channel allocator.
// Holds the request/result payload structs and the controller/datapath handshake.
// No dependencies.
`default_nettype none

package noc_vca_pkg;

  localparam int unsigned NUM_DIRS = 4;

  localparam int unsigned MODE_W  = 1;
  localparam int unsigned PORT_W  = 3;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned QOS_W   = 2;
  localparam int unsigned VCIDX_W = 2;
  localparam int unsigned VCID_W  = 3;
  localparam int unsigned GT_W    = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_QOS_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GT_COUNT   = 2'd1;

  localparam logic [GT_W-1:0] GT_COUNT_RESET = 3'd2;

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_REQ    = 1'b0;
  localparam logic [MODE_W-1:0] MODE_CREDIT = 1'b1;

  // QoS classes
  localparam logic [QOS_W-1:0] QOS_ANY  = 2'd0;
  localparam logic [QOS_W-1:0] QOS_GT   = 2'd1;
  localparam logic [QOS_W-1:0] QOS_BE   = 2'd2;
  localparam logic [QOS_W-1:0] QOS_NONE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PORT_W-1:0]  requester_port;
    logic [DIR_W-1:0]   direction;
    logic [QOS_W-1:0]   qos_class;
    logic [VCIDX_W-1:0] vc_index;
    logic               vc_free;
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] grant_port;
    logic [VCID_W-1:0] vc_id;
    logic              granted;
    logic              congestion;
  } rsp_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic is_req;
  } dp_sts_t;

endpackage

`default_nettype wire

[hdl/noc_vc_first_free_allocator.sv]
// First-free virtual channel allocator for four output directions.
// An accepted item is loaded into the item register and executes once the result
// register is free or draining; a request's result is then registered as valid. The
// single item register and two-step sequencer take no new item until the last executes.
// Reset: all channels free, congestion clear, qos_enable 0, gt_count 2.
// Depends on noc_vca_pkg, noc_vca_ctrl, noc_vca_dp.
`default_nettype none

module noc_vc_first_free_allocator #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire noc_vca_pkg::req_t                  in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output noc_vca_pkg::rsp_t                       out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [noc_vca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [noc_vca_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import noc_vca_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  noc_vca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  noc_vca_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

  // A failed request always reports congestion
  a_fail_congested : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.granted |-> out_data_o.congestion)
    else $error("failed grant without congestion");

  // A granted channel lies inside the channel count
  a_grant_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted && (NUM_CHANNELS < 8)
      |-> (32'(out_data_o.vc_id) < NUM_CHANNELS))
    else $error("granted channel out of range");

  // An accepted transfer blocks the input for the execute step
  a_exec_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off during execute");

  // A result is loaded only by a request being executed
  a_result_from_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_result |-> (cmd.exec && sts.is_req))
    else $error("result loaded without a request");

endmodule

`default_nettype wire

[hdl/noc_vca_ctrl.sv]
// Sequencer for the allocator: input handshake, execute step, result valid.
// Depends on noc_vca_pkg.
`default_nettype none

module noc_vca_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output noc_vca_pkg::dp_cmd_t      cmd_o,
  input  wire noc_vca_pkg::dp_sts_t sts_i
);
  import noc_vca_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_take, out_take, can_finish;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  // A request may only finish once the result register is free or draining.
  assign can_finish  = !sts_i.is_req || !out_valid_q || out_take;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d           = state_q;
    cmd_o.load_item   = 1'b0;
    cmd_o.exec        = 1'b0;
    cmd_o.load_result = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (can_finish) begin
          cmd_o.exec        = 1'b1;
          cmd_o.load_result = sts_i.is_req;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[hdl/noc_vca_dp.sv]
// Datapath: item register, config registers, free maps, congestion flag,
// range mask and lowest-free search, result register. Depends on noc_vca_pkg.
`default_nettype none

module noc_vca_dp #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire noc_vca_pkg::dp_cmd_t                 cmd_i,
  output noc_vca_pkg::dp_sts_t                      sts_o,
  input  wire noc_vca_pkg::req_t                    in_data_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [noc_vca_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [noc_vca_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output noc_vca_pkg::rsp_t                         out_data_o
);
  import noc_vca_pkg::*;

  localparam int unsigned CW = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [VCID_W-1:0] VcNone = VCID_W'(NUM_CHANNELS + 1);

  req_t                    item_q;
  rsp_t                    rsp_q, rsp_d;
  logic                    qos_enable_q;
  logic [GT_W-1:0]         gt_count_q;
  logic [NUM_CHANNELS-1:0] free_map_q [NUM_DIRS];
  logic [NUM_CHANNELS-1:0] free_map_d [NUM_DIRS];
  logic                    congested_q, congested_d;

  logic [QOS_W-1:0]        cls;
  logic [CW-1:0]           gt, lo, hi;
  logic [NUM_CHANNELS-1:0] cur_free, rng, cand, take, cred;
  logic [NUM_CHANNELS-1:0] next_free;
  logic                    found;
  logic [IW-1:0]           idx;

  assign sts_o.is_req = (item_q.mode == MODE_REQ);
  assign out_data_o   = rsp_q;

  // Search range from class and clamped guaranteed count
  always_comb begin
    cls = qos_enable_q ? item_q.qos_class : QOS_ANY;
    if (32'(gt_count_q) > NUM_CHANNELS) begin
      gt = CW'(NUM_CHANNELS);
    end else begin
      gt = CW'(gt_count_q);
    end
    case (cls)
      QOS_ANY: begin
        lo = '0;
        hi = CW'(NUM_CHANNELS);
      end
      QOS_GT: begin
        lo = '0;
        hi = gt;
      end
      QOS_BE: begin
        lo = gt;
        hi = CW'(NUM_CHANNELS);
      end
      default: begin
        lo = '0;
        hi = '0;
      end
    endcase
  end

  // Lowest free channel inside the range; one-hot pick then encode
  always_comb begin
    cur_free = free_map_q[item_q.direction];
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      rng[c]  = (CW'(c) >= lo) && (CW'(c) < hi);
      cred[c] = (int'(item_q.vc_index) == c);
    end
    cand  = cur_free & rng;
    take  = cand & (~cand + NUM_CHANNELS'(1));
    found = |cand;
    idx   = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (take[c]) begin
        idx = idx | IW'(c);
      end
    end
  end

  always_comb begin
    if (item_q.mode == MODE_CREDIT) begin
      next_free = item_q.vc_free ? (cur_free | cred) : (cur_free & ~cred);
    end else begin
      next_free = cur_free & ~take;
    end
    for (int d = 0; d < NUM_DIRS; d++) begin
      free_map_d[d] = free_map_q[d];
    end
    congested_d = congested_q;
    if (cmd_i.exec) begin
      free_map_d[item_q.direction] = next_free;
      if (item_q.mode == MODE_REQ && !found) begin
        congested_d = 1'b1;
      end
    end
    rsp_d.grant_port = item_q.requester_port;
    rsp_d.vc_id      = found ? VCID_W'(idx) : VcNone;
    rsp_d.granted    = found;
    rsp_d.congestion = congested_q | !found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qos_enable_q <= 1'b0;
      gt_count_q   <= GT_COUNT_RESET;
      congested_q  <= 1'b0;
      for (int d = 0; d < NUM_DIRS; d++) begin
        free_map_q[d] <= '1;
      end
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_QOS_ENABLE) begin
        qos_enable_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_index_i == CFG_GT_COUNT) begin
        gt_count_q <= cfg_data_i;
      end
      congested_q <= congested_d;
      for (int d = 0; d < NUM_DIRS; d++) begin
        free_map_q[d] <= free_map_d[d];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_result) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

`default_nettype wire
